// ===== src/assert_macros.svh =====
// Assertion macros used by the engine's top level.
// No dependencies; the including file supplies clock, reset and property.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge once reset has been released.
`define LCE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// When the trigger holds, the expectation must hold in the next cycle.
`define LCE_ASSERT_NEXT(label, clk, rst_n, trig, expect_next, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (trig) |=> (expect_next)) else $error(msg);

`endif

// ===== src/lce_pkg.sv =====
// Shared types and constants of the life cellular automaton engine.
// No dependencies; lce_ctrl, lce_dp and the top level refer to it.
`timescale 1ns / 1ps
`default_nettype none

package lce_pkg;

    typedef logic [1:0] t_opcode;

    localparam t_opcode OP_WRITE = 2'd0;
    localparam t_opcode OP_READ  = 2'd1;
    localparam t_opcode OP_CLEAR = 2'd2;
    localparam t_opcode OP_STEP  = 2'd3;

    // B3/S23 rule thresholds.
    localparam int BIRTH_COUNT = 3;
    localparam int SURVIVE_MIN = 2;
    localparam int CROWD_COUNT = 4;

    typedef logic [3:0] t_count;

    typedef struct packed {
        t_opcode    opcode;
        logic [7:0] cell_col;
        logic [7:0] cell_row;
        logic       cell_value;
    } t_in_word;

    typedef struct packed {
        logic    cell_alive;
        t_opcode done_opcode;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic exec;
        logic capture;
        logic clear_wr;
        logic scan;
        logic out_load;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_opcode opcode;
        logic    wr_last;
        logic    scan_last;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== src/lce_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lce_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/lce_ctrl.sv =====
// Controller of the life engine: sequences clear passes, cell accesses,
// generation sweeps and the result word. Depends on lce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lce_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  lce_pkg::t_dp_status i_status,
    output lce_pkg::t_ctl_cmd   o_cmd
);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DISP   = 4'd2;
    localparam logic [3:0] S_RCAP   = 4'd3;
    localparam logic [3:0] S_CLEAR  = 4'd4;
    localparam logic [3:0] S_STEP   = 4'd5;
    localparam logic [3:0] S_DRAIN1 = 4'd6;
    localparam logic [3:0] S_DRAIN2 = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.clear_wr = 1'b1;
                if (i_status.wr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DISP;
                end
            end
            S_DISP: begin
                case (i_status.opcode)
                    lce_pkg::OP_WRITE: begin
                        o_cmd.exec = 1'b1;
                        n_state    = S_DONE;
                    end
                    lce_pkg::OP_READ: begin
                        o_cmd.exec = 1'b1;
                        n_state    = S_RCAP;
                    end
                    lce_pkg::OP_CLEAR: begin
                        n_state = S_CLEAR;
                    end
                    lce_pkg::OP_STEP: begin
                        n_state = S_STEP;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RCAP: begin
                o_cmd.capture = 1'b1;
                n_state       = S_DONE;
            end
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_status.wr_last) begin
                    n_state = S_DONE;
                end
            end
            S_STEP: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN1;
                end
            end
            // S_DRAIN1 and S_DRAIN2 let the last column leave the window and be written back.
            S_DRAIN1: begin
                n_state = S_DRAIN2;
            end
            S_DRAIN2: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== src/lce_dp.sv =====
// Datapath of the life engine: board and column line memories, the sweep
// counters, the 3x3 neighbourhood window and the result word. Depends on
// lce_pkg and lce_ram.
`timescale 1ns / 1ps
`default_nettype none

module lce_dp #(
    parameter int BOARD_COLS = 256,
    parameter int BOARD_ROWS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lce_pkg::t_in_word   i_in_word,
    input  lce_pkg::t_ctl_cmd   i_cmd,
    output lce_pkg::t_dp_status o_status,
    output lce_pkg::t_out_word  o_out_word
);

    localparam int CELLS = BOARD_COLS * BOARD_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int LAW   = $clog2(BOARD_ROWS);
    localparam int CW    = $clog2(BOARD_COLS + 1);
    localparam int RW    = $clog2(BOARD_ROWS + 1);

    lce_pkg::t_in_word  r_item;
    lce_pkg::t_out_word r_out_word;
    logic               r_rd_inb;
    logic               r_alive;

    // Sweep position: column and row of the cell entering the window.
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [AW-1:0] r_rd_addr;
    logic [AW-1:0] r_wr_addr;

    logic          r_s1_valid;
    logic [RW-1:0] r_s1_row;
    logic          r_s1_pad;
    logic          r_s1_first;
    logic          r_s1_prior_dead;
    logic          r_s1_next_dead;
    logic          r_s1_emit;
    logic          r_s2_valid;

    // Window rows, each {left column, centre column, right column}.
    logic [2:0] r_win_top;
    logic [2:0] r_win_mid;
    logic [2:0] r_win_bot;

    logic           w_row_pad;
    logic           w_col_end;
    logic           w_brd_rd;
    logic           w_inb;
    logic [AW-1:0]  w_cell_addr;
    logic           w_brd_we;
    logic [AW-1:0]  w_brd_waddr;
    logic           w_brd_wdata;
    logic [AW-1:0]  w_brd_raddr;
    logic           w_brd_rdata;
    logic           w_line_we;
    logic [1:0]     w_line_wdata;
    logic [1:0]     w_line_rdata;
    logic           w_next;
    logic           w_cur;
    logic           w_prior;
    lce_pkg::t_count w_count;
    logic           w_new;

    assign w_row_pad = (r_row == RW'(BOARD_ROWS));
    assign w_col_end = (r_col == CW'(BOARD_COLS));
    assign w_brd_rd  = i_cmd.scan && !w_row_pad && !w_col_end;

    assign w_inb = (32'(r_item.cell_col) < 32'(BOARD_COLS))
                && (32'(r_item.cell_row) < 32'(BOARD_ROWS));
    assign w_cell_addr = AW'(r_item.cell_col) * AW'(BOARD_ROWS) + AW'(r_item.cell_row);

    // Stage one: the old cell of the right column plus the line memory,
    // which holds the old values of the centre and left columns.
    assign w_next  = (r_s1_pad || r_s1_next_dead) ? 1'b0 : w_brd_rdata;
    assign w_cur   = r_s1_pad ? 1'b0 : w_line_rdata[0];
    assign w_prior = (r_s1_pad || r_s1_prior_dead) ? 1'b0 : w_line_rdata[1];

    assign w_line_we    = r_s1_valid && !r_s1_pad;
    assign w_line_wdata = {w_line_rdata[0], w_next};

    // Stage two: B3/S23 rule on the centre of the window.
    assign w_count = lce_pkg::t_count'(r_win_top[2]) + lce_pkg::t_count'(r_win_top[1])
                   + lce_pkg::t_count'(r_win_top[0]) + lce_pkg::t_count'(r_win_mid[2])
                   + lce_pkg::t_count'(r_win_mid[0]) + lce_pkg::t_count'(r_win_bot[2])
                   + lce_pkg::t_count'(r_win_bot[1]) + lce_pkg::t_count'(r_win_bot[0]);

    always_comb begin
        if (r_win_mid[1]) begin
            w_new = (w_count >= lce_pkg::t_count'(lce_pkg::SURVIVE_MIN))
                 && (w_count < lce_pkg::t_count'(lce_pkg::CROWD_COUNT));
        end else begin
            w_new = (w_count == lce_pkg::t_count'(lce_pkg::BIRTH_COUNT));
        end
    end

    assign w_brd_we = i_cmd.clear_wr
                   || (i_cmd.exec && (r_item.opcode == lce_pkg::OP_WRITE) && w_inb)
                   || r_s2_valid;
    assign w_brd_waddr = i_cmd.exec ? w_cell_addr : r_wr_addr;
    always_comb begin
        if (i_cmd.clear_wr) begin
            w_brd_wdata = 1'b0;
        end else if (i_cmd.exec) begin
            w_brd_wdata = r_item.cell_value;
        end else begin
            w_brd_wdata = w_new;
        end
    end
    assign w_brd_raddr = i_cmd.exec ? w_cell_addr : r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_rd_addr  <= '0;
            r_wr_addr  <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_col     <= '0;
                r_row     <= '0;
                r_rd_addr <= '0;
                r_wr_addr <= '0;
            end else begin
                if (i_cmd.scan) begin
                    if (w_row_pad) begin
                        r_row <= '0;
                        r_col <= r_col + CW'(1);
                    end else begin
                        r_row <= r_row + RW'(1);
                    end
                end
                if (w_brd_rd) begin
                    r_rd_addr <= r_rd_addr + AW'(1);
                end
                if (i_cmd.clear_wr || r_s2_valid) begin
                    r_wr_addr <= r_wr_addr + AW'(1);
                end
            end
            r_s1_valid <= i_cmd.scan;
            r_s2_valid <= r_s1_valid && r_s1_emit && !r_s1_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item  <= i_in_word;
            r_alive <= 1'b0;
        end
        if (i_cmd.exec) begin
            r_rd_inb <= w_inb;
        end
        if (i_cmd.capture) begin
            r_alive <= w_brd_rdata & r_rd_inb;
        end
        if (i_cmd.scan) begin
            r_s1_row        <= r_row;
            r_s1_pad        <= w_row_pad;
            r_s1_first      <= (r_row == '0);
            r_s1_prior_dead <= (r_col <= CW'(1));
            r_s1_next_dead  <= w_col_end;
            r_s1_emit       <= (r_col != '0);
        end
        if (r_s1_valid) begin
            // The first row of a column starts with the dead row above the board.
            r_win_top <= r_s1_first ? 3'b000 : r_win_mid;
            r_win_mid <= r_s1_first ? 3'b000 : r_win_bot;
            r_win_bot <= {w_prior, w_cur, w_next};
        end
        if (i_cmd.out_load) begin
            r_out_word.cell_alive  <= r_alive;
            r_out_word.done_opcode <= r_item.opcode;
        end
    end

    lce_ram #(
        .WIDTH(1),
        .DEPTH(CELLS)
    ) u_board (
        .i_clk  (i_clk),
        .i_we   (w_brd_we),
        .i_waddr(w_brd_waddr),
        .i_wdata(w_brd_wdata),
        .i_raddr(w_brd_raddr),
        .o_rdata(w_brd_rdata)
    );

    // Bit 1 holds the old left column, bit 0 the old centre column.
    lce_ram #(
        .WIDTH(2),
        .DEPTH(BOARD_ROWS)
    ) u_lines (
        .i_clk  (i_clk),
        .i_we   (w_line_we),
        .i_waddr(r_s1_row[LAW-1:0]),
        .i_wdata(w_line_wdata),
        .i_raddr(r_row[LAW-1:0]),
        .o_rdata(w_line_rdata)
    );

    assign o_status.opcode    = r_item.opcode;
    assign o_status.wr_last   = (r_wr_addr == AW'(CELLS - 1));
    assign o_status.scan_last = w_col_end && w_row_pad;
    assign o_out_word         = r_out_word;

endmodule

`default_nettype wire

// ===== src/life_cellular_automaton_engine_top.sv =====
// Top level of the life cellular automaton engine (B3/S23, dead border).
// Depends on lce_pkg, lce_ctrl, lce_dp, lce_ram and assert_macros.svh.
//
//   Channel  Direction  Handshake                  Word
//   input    in         i_in_valid / o_in_stall    i_in_word  (t_in_word)
//   result   out        o_out_valid / i_out_stall  o_out_word (t_out_word)
//
// Write passes through S_DISP to S_DONE; read adds S_RCAP, where the cell
// read from the board is captured. Clear writes one cell per cycle on the
// single write port of the board memory. A generation sweep visits
// (BOARD_COLS+1)*(BOARD_ROWS+1) positions: one cell per cycle through the
// board read port plus one padding row and column.
// After reset a clearing pass runs before the first word is taken. One word
// is in work at a time; a finished result waits in the output register and
// the next word is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module life_cellular_automaton_engine_top #(
    parameter int BOARD_COLS = 256,
    parameter int BOARD_ROWS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lce_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lce_pkg::t_out_word o_out_word
);

    lce_pkg::t_ctl_cmd   w_cmd;
    lce_pkg::t_dp_status w_stat;

    lce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_status   (w_stat),
        .o_cmd      (w_cmd)
    );

    lce_dp #(
        .BOARD_COLS(BOARD_COLS),
        .BOARD_ROWS(BOARD_ROWS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_word (i_in_word),
        .i_cmd     (w_cmd),
        .o_status  (w_stat),
        .o_out_word(o_out_word)
    );

    `LCE_ASSERT_NEXT(a_accept_blocks, i_clk, i_rst_n, i_in_valid && !o_in_stall,
                     o_in_stall, "input taken while a word is in work")
    `LCE_ASSERT(a_one_command, i_clk, i_rst_n, $onehot0(w_cmd),
                "controller issued two commands at once")
    `LCE_ASSERT(a_load_free, i_clk, i_rst_n, !w_cmd.out_load || !o_out_valid || !i_out_stall,
                "result overwrote a word not yet taken")
    `LCE_ASSERT_NEXT(a_scan_stops, i_clk, i_rst_n, w_cmd.scan && w_stat.scan_last,
                     !w_cmd.scan, "sweep ran past the last board position")

endmodule

`default_nettype wire
